// File: design/kvcp_pkg.sv
// ----------------------------------------------------------------------------
// kvcp_pkg
// Shared types, character codes and key name tables for the key/value
// command parser.
// ----------------------------------------------------------------------------
package kvcp_pkg;

   // key table
   localparam int NumKeys = 4;

   typedef logic [NumKeys-1:0] key_vec_type;
   typedef logic [1:0]         key_id_type;
   typedef logic [2:0]         key_pos_type;
   typedef logic [7:0]         char_type;
   typedef logic signed [31:0] value_type;

   // control passed from the top level to the key and value sections
   typedef struct packed {
      logic step;       // an item is processed this cycle
      logic restart;    // first byte of a command, pair state starts over
      logic is_equal;   // byte is '='
      logic is_end;     // byte is ',' or the end code
   } step_ctl_type;

   // character codes
   localparam char_type CharEqual = 8'h3D;
   localparam char_type CharComma = 8'h2C;
   localparam char_type CharPlus  = 8'h2B;
   localparam char_type CharMinus = 8'h2D;
   localparam char_type CharSpace = 8'h20;
   localparam char_type CharTab   = 8'h09;
   localparam char_type CharCr    = 8'h0D;
   localparam char_type CharZero  = 8'h30;
   localparam char_type CharNine  = 8'h39;

   // configuration registers
   localparam logic     RegEndCode   = 1'b0;
   localparam char_type EndCodeReset = 8'hFF;

   // key ids
   localparam key_id_type KeyT1     = 2'd0;
   localparam key_id_type KeyT2     = 2'd1;
   localparam key_id_type KeyNumber = 2'd2;
   localparam key_id_type KeyMode   = 2'd3;

   // length of each key name
   function automatic key_pos_type key_len(input key_id_type idx);
      key_pos_type len;
      case (idx)
         KeyT1:     len = 3'd2;
         KeyT2:     len = 3'd2;
         KeyNumber: len = 3'd6;
         default:   len = 3'd4;
      endcase
      return len;
   endfunction

   // character of a key name at a given position, zero past the end
   function automatic char_type key_char(input key_id_type idx, input key_pos_type pos);
      char_type c;
      c = 8'h00;
      case (idx)
         KeyT1: begin
            case (pos)
               3'd0:    c = "t";
               3'd1:    c = "1";
               default: c = 8'h00;
            endcase
         end
         KeyT2: begin
            case (pos)
               3'd0:    c = "t";
               3'd1:    c = "2";
               default: c = 8'h00;
            endcase
         end
         KeyNumber: begin
            case (pos)
               3'd0:    c = "n";
               3'd1:    c = "u";
               3'd2:    c = "m";
               3'd3:    c = "b";
               3'd4:    c = "e";
               3'd5:    c = "r";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               3'd0:    c = "m";
               3'd1:    c = "o";
               3'd2:    c = "d";
               3'd3:    c = "e";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

// File: design/kvcp_key_match.sv
// ----------------------------------------------------------------------------
// kvcp_key_match
// Tracks the key of the current pair: position, which names still match,
// and whether the '=' has been seen.
// ----------------------------------------------------------------------------
module kvcp_key_match
   import kvcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_ctl_type ctl,
   input  char_type     byte_in,
   output logic         equal_now,
   output key_vec_type  match_now
);

   key_pos_type pos_ff, pos_in;
   key_vec_type match_ff, match_in;
   logic        equal_ff, equal_in;

   key_pos_type pos_cur;

   // pair state as seen by this byte, restarted on the first byte
   assign pos_cur   = ctl.restart ? '0 : pos_ff;
   assign match_now = ctl.restart ? '1 : match_ff;
   assign equal_now = ctl.restart ? 1'b0 : equal_ff;

   // next key state
   always_comb begin
      pos_in   = pos_cur;
      match_in = match_now;
      equal_in = equal_now;
      if (ctl.is_equal) begin
         if (!equal_now) begin
            for (int i = 0; i < NumKeys; i++) begin
               if (pos_cur != key_len(key_id_type'(i))) match_in[i] = 1'b0;
            end
            equal_in = 1'b1;
         end else begin
            match_in = '0;
         end
      end else if (ctl.is_end) begin
         pos_in   = '0;
         match_in = '1;
         equal_in = 1'b0;
      end else if (!equal_now) begin
         for (int i = 0; i < NumKeys; i++) begin
            if (pos_cur >= key_len(key_id_type'(i)) ||
                key_char(key_id_type'(i), pos_cur) != byte_in) match_in[i] = 1'b0;
         end
         if (pos_cur != 3'd7) pos_in = pos_cur + 3'd1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= '1;
         equal_ff <= 1'b0;
      end else if (ctl.step) begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
         equal_ff <= equal_in;
      end
   end

endmodule

// File: design/kvcp_value_conv.sv
// ----------------------------------------------------------------------------
// kvcp_value_conv
// Decimal conversion of the value part: blank skip, optional sign, then
// multiply-by-ten accumulate with saturation at the 32-bit bounds.
// ----------------------------------------------------------------------------
module kvcp_value_conv
   import kvcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_ctl_type ctl,
   input  char_type     byte_in,
   input  logic         equal_now,
   output value_type    value_now
);

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_ENDED  = 2'd2,
      PHASE_SPARE  = 2'd3
   } phase_type;

   localparam logic signed [35:0] AccMax = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] AccMin = -36'sh0_8000_0000;

   phase_type phase_ff, phase_in, phase_cur;
   logic      neg_ff, neg_in, neg_cur;
   value_type acc_ff, acc_in;

   logic              is_blank, is_sign, is_digit;
   logic signed [35:0] acc_wide, acc_times10, acc_sum;
   logic signed [35:0] digit;

   // pair state as seen by this byte
   assign phase_cur = ctl.restart ? PHASE_SKIP : phase_ff;
   assign neg_cur   = ctl.restart ? 1'b0 : neg_ff;
   assign value_now = ctl.restart ? '0 : acc_ff;

   // byte classes
   assign is_blank = (byte_in == CharSpace) || (byte_in >= CharTab && byte_in <= CharCr);
   assign is_sign  = (byte_in == CharPlus) || (byte_in == CharMinus);
   assign is_digit = (byte_in >= CharZero) && (byte_in <= CharNine);

   // multiply by ten as two shifts and an add, then add or subtract the digit
   assign acc_wide    = 36'(value_now);
   assign acc_times10 = (acc_wide <<< 3) + (acc_wide <<< 1);
   assign digit       = $signed({32'd0, byte_in[3:0]});
   assign acc_sum     = neg_cur ? (acc_times10 - digit) : (acc_times10 + digit);

   // next value state
   always_comb begin
      phase_in = phase_cur;
      neg_in   = neg_cur;
      acc_in   = value_now;
      if (ctl.is_equal || ctl.is_end) begin
         phase_in = PHASE_SKIP;
         neg_in   = 1'b0;
         acc_in   = '0;
      end else if (equal_now) begin
         if (phase_cur == PHASE_SKIP && is_blank) begin
            phase_in = PHASE_SKIP;
         end else if (phase_cur == PHASE_SKIP && is_sign) begin
            neg_in   = (byte_in == CharMinus);
            phase_in = PHASE_DIGITS;
         end else if ((phase_cur == PHASE_SKIP || phase_cur == PHASE_DIGITS) && is_digit) begin
            if (acc_sum > AccMax)      acc_in = AccMax[31:0];
            else if (acc_sum < AccMin) acc_in = AccMin[31:0];
            else                       acc_in = acc_sum[31:0];
            phase_in = PHASE_DIGITS;
         end else begin
            phase_in = PHASE_ENDED;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (ctl.step) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

// File: design/key_value_command_parser.sv
// ----------------------------------------------------------------------------
// key_value_command_parser
// Parses key=value,key=value command text one byte per item and emits the
// key id and decimal value of each known key.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per item in req_tdata, req_tuser set on the
//   first byte of a command (all pair state starts over before that byte).
//   rsp channel: one item per pair closed by ',' or the end code, when the
//   key is t1, t2, number or mode and the pair held an '='. rsp_tuser is the
//   key id, rsp_tdata the signed 32-bit value (saturated).
//   csr port: register 0 at address 0 is the end code, reset value 255.
// Timing:
//   an item is registered on acceptance, parsed from the input register once
//   the result register is free, and its result registered then. One item
//   per cycle is sustained while the receiver does not stall; the loop on
//   the value is the multiply-by-ten accumulate.
// Reset clears the pair state and the valid flags of both pipeline stages, and sets the end code to 255.
// When the receiver stalls a waiting result holds and one more byte is taken
// into the input register if that is empty, then req_tready drops.
// ----------------------------------------------------------------------------
module key_value_command_parser
   import kvcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] first_of_command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] field_value
   output logic [1:0]  rsp_tuser,   // [1:0] key_id
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic         in_valid_ff, in_valid_in;
   char_type     in_byte_ff;
   logic         in_first_ff;
   logic         out_valid_ff, out_valid_in;
   key_id_type   out_key_ff;
   value_type    out_value_ff;
   char_type     end_code_ff;

   logic         out_free;
   logic         fire;
   step_ctl_type ctl;
   logic         equal_now;
   key_vec_type  match_now;
   value_type    value_now;
   key_id_type   key_sel;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegEndCode) ? {24'd0, end_code_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_code_ff <= EndCodeReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == RegEndCode) begin
         end_code_ff <= csr_pwdata[7:0];
      end
   end

   // handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_free;

   // control for this cycle's byte
   assign ctl.step     = in_valid_ff && out_free;
   assign ctl.restart  = in_first_ff;
   assign ctl.is_equal = (in_byte_ff == CharEqual);
   assign ctl.is_end   = !ctl.is_equal &&
                         (in_byte_ff == CharComma || in_byte_ff == end_code_ff);

   kvcp_key_match u_key (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .byte_in   (in_byte_ff),
      .equal_now (equal_now),
      .match_now (match_now)
   );

   kvcp_value_conv u_value (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .byte_in   (in_byte_ff),
      .equal_now (equal_now),
      .value_now (value_now)
   );

   // lowest matching key wins
   always_comb begin
      key_sel = KeyMode;
      for (int i = NumKeys - 1; i >= 0; i--) begin
         if (match_now[i]) key_sel = key_id_type'(i);
      end
   end

   assign fire = ctl.step && ctl.is_end && equal_now && (match_now != '0);

   // valid flags of both stages
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
      if (fire) begin
         out_key_ff   <= key_sel;
         out_value_ff <= value_now;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_key_ff;

endmodule

// File: design/kvcp_checker.sv
// ----------------------------------------------------------------------------
// kvcp_checker
// Port-level checks for the key/value command parser, bound to the top level.
// ----------------------------------------------------------------------------
module kvcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_pready
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a taken result frees the input side in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while result side is free");

   // every new result must follow an accepted item, with csr_pready high
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2) && csr_pready)
      else $error("result without an accepted item");

endmodule

bind key_value_command_parser kvcp_checker u_kvcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
